FILE: rtl/hpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types and constants for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

   localparam int HEAP_DEPTH = 64;
   localparam int ADDR_W     = $clog2(HEAP_DEPTH);
   localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
   localparam int TAG_W      = 16;
   localparam int PRI_W      = 16;
   localparam int KEY_W      = PRI_W + TAG_W;
   localparam int STAT_W     = 3;
   localparam int COUNT_W    = 7;

   typedef enum logic [1:0] {
      OP_ENQ = 2'd0,
      OP_DEQ = 2'd1,
      OP_CHG = 2'd2,
      OP_CLR = 2'd3
   } op_type;

   localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY       = 3'd1;
   localparam logic [STAT_W-1:0] ST_FULL        = 3'd2;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND   = 3'd3;
   localparam logic [STAT_W-1:0] ST_MORE_URGENT = 3'd4;

   typedef struct packed {
      op_type             op;
      logic [TAG_W-1:0]   value_tag;
      logic [PRI_W-1:0]   priority_req;
   } req_payload_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [TAG_W-1:0]   value_out;
      logic [PRI_W-1:0]   priority_out;
      logic [COUNT_W-1:0] count_out;
      logic [TAG_W-1:0]   head_tag;
      logic [PRI_W-1:0]   head_priority;
   } rsp_payload_type;

   // controller states; the datapath command is the current state
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DQ_ROOT,
      S_DQ_LAST,
      S_DN_CHECK,
      S_DN_LEFT,
      S_DN_RIGHT,
      S_DN_CMP,
      S_SR_RD,
      S_SR_CMP,
      S_HEAD,
      S_HEAD_CAP,
      S_FINISH
   } state_type;

   typedef struct packed {
      state_type step;
      logic      load;    // capture request payload
      logic      finish;  // load result register
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   cnt_one;
      logic   p_one;
      logic   up_less;
      logic   dn_leaf;
      logic   right_ok;
      logic   dn_less;
      logic   tag_hit;
      logic   urgent;
      logic   p_at_cnt;
   } flags_type;

endpackage

FILE: rtl/hpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/hpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_datapath
// Heap storage, position and key registers, compares and result register.
// ----------------------------------------------------------------------------
module hpq_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  hpq_pkg::cmd_type        cmd,
   input  hpq_pkg::req_payload_type req_payload,
   output hpq_pkg::flags_type      flags,
   output hpq_pkg::rsp_payload_type rsp_payload
);
   import hpq_pkg::*;

   op_type              op_ff, op_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [PRI_W-1:0]    pri_ff, pri_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    p_ff, p_in;
   logic [CNT_W:0]      c_ff, c_in;
   logic [KEY_W-1:0]    e_ff, e_in;
   logic [KEY_W-1:0]    cv_ff, cv_in;
   logic [KEY_W-1:0]    head_ff, head_in;
   logic [STAT_W-1:0]   stat_ff, stat_in;
   logic [KEY_W-1:0]    rem_ff, rem_in;
   rsp_payload_type     rsp_ff, rsp_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr, rd_addr, p_addr;
   logic [KEY_W-1:0]    wr_data, rd_data;
   logic [CNT_W:0]      two_p;

   hpq_ram #(.WIDTH(KEY_W), .DEPTH(HEAP_DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign two_p  = {p_ff, 1'b0};
   assign p_addr = ADDR_W'(p_ff - 1'b1);

   always_comb begin
      flags.op       = op_ff;
      flags.full     = (cnt_ff == CNT_W'(HEAP_DEPTH));
      flags.empty    = (cnt_ff == '0);
      flags.cnt_one  = (cnt_ff == CNT_W'(1));
      flags.p_one    = (p_ff == CNT_W'(1));
      flags.up_less  = (e_ff < rd_data);
      flags.dn_leaf  = (two_p > {1'b0, cnt_ff});
      flags.right_ok = ((c_ff + 1'b1) <= {1'b0, cnt_ff});
      flags.dn_less  = (cv_ff < e_ff);
      flags.tag_hit  = (rd_data[TAG_W-1:0] == tag_ff);
      flags.urgent   = (rd_data[KEY_W-1:TAG_W] <= pri_ff);
      flags.p_at_cnt = (p_ff == cnt_ff);
   end

   always_comb begin
      op_in   = op_ff;
      tag_in  = tag_ff;
      pri_in  = pri_ff;
      cnt_in  = cnt_ff;
      p_in    = p_ff;
      c_in    = c_ff;
      e_in    = e_ff;
      cv_in   = cv_ff;
      head_in = head_ff;
      stat_in = stat_ff;
      rem_in  = rem_ff;
      rsp_in  = rsp_ff;
      wr_en   = 1'b0;
      wr_addr = p_addr;
      wr_data = e_ff;
      rd_addr = '0;

      if (cmd.load) begin
         op_in  = req_payload.op;
         tag_in = req_payload.value_tag;
         pri_in = req_payload.priority_req;
      end

      unique case (cmd.step)
         S_DECODE: begin
            stat_in = ST_OK;
            rem_in  = '0;
            unique case (op_ff)
               OP_ENQ: begin
                  if (flags.full) begin
                     stat_in = ST_FULL;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                     p_in   = cnt_ff + 1'b1;
                     e_in   = {pri_ff, tag_ff};
                  end
               end
               OP_DEQ: begin
                  if (flags.empty) stat_in = ST_EMPTY;
               end
               OP_CHG: begin
                  p_in = CNT_W'(1);
                  if (flags.empty) stat_in = ST_NOT_FOUND;
               end
               OP_CLR: cnt_in = '0;
               default: ;
            endcase
         end
         S_UP_CHECK: begin
            rd_addr = ADDR_W'((p_ff >> 1) - 1'b1);
            wr_en   = flags.p_one;
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (flags.up_less) begin
               wr_data = rd_data;
               p_in    = p_ff >> 1;
            end
         end
         S_DQ_ROOT: begin
            rem_in  = rd_data;
            rd_addr = ADDR_W'(cnt_ff - 1'b1);
         end
         S_DQ_LAST: begin
            e_in   = rd_data;
            cnt_in = cnt_ff - 1'b1;
            p_in   = CNT_W'(1);
         end
         S_DN_CHECK: begin
            c_in    = two_p;
            rd_addr = ADDR_W'(two_p - 1'b1);
            wr_en   = flags.dn_leaf;
         end
         S_DN_LEFT: begin
            cv_in   = rd_data;
            rd_addr = c_ff[ADDR_W-1:0];   // right child c+1 lives at c
         end
         S_DN_RIGHT: begin
            if (rd_data < cv_ff) begin
               cv_in = rd_data;
               c_in  = c_ff + 1'b1;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (flags.dn_less) begin
               wr_data = cv_ff;
               p_in    = c_ff[CNT_W-1:0];
            end
         end
         S_SR_RD: rd_addr = p_addr;
         S_SR_CMP: begin
            if (flags.tag_hit) begin
               if (flags.urgent) stat_in = ST_MORE_URGENT;
               else              e_in    = {pri_ff, tag_ff};
            end else if (flags.p_at_cnt) begin
               stat_in = ST_NOT_FOUND;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         S_HEAD: rd_addr = '0;
         S_HEAD_CAP: head_in = flags.empty ? '0 : rd_data;
         default: ;
      endcase

      if (cmd.finish) begin
         rsp_in.status        = stat_ff;
         rsp_in.value_out     = rem_ff[TAG_W-1:0];
         rsp_in.priority_out  = rem_ff[KEY_W-1:TAG_W];
         rsp_in.count_out     = COUNT_W'(cnt_ff);
         rsp_in.head_tag      = head_ff[TAG_W-1:0];
         rsp_in.head_priority = head_ff[KEY_W-1:TAG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      op_ff   <= op_in;
      tag_ff  <= tag_in;
      pri_ff  <= pri_in;
      p_ff    <= p_in;
      c_ff    <= c_in;
      e_ff    <= e_in;
      cv_ff   <= cv_in;
      head_ff <= head_in;
      stat_ff <= stat_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/hpq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpq_controller
// Sequencer for enqueue, dequeue, change-priority and clear.
// ----------------------------------------------------------------------------
module hpq_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  hpq_pkg::flags_type flags,
   output hpq_pkg::cmd_type   cmd
);
   import hpq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            unique case (flags.op)
               OP_ENQ: state_in = flags.full  ? S_HEAD : S_UP_CHECK;
               OP_DEQ: state_in = flags.empty ? S_HEAD : S_DQ_ROOT;
               OP_CHG: state_in = flags.empty ? S_HEAD : S_SR_RD;
               OP_CLR: state_in = S_HEAD;
               default: state_in = S_HEAD;
            endcase
         end
         S_UP_CHECK: state_in = flags.p_one ? S_HEAD : S_UP_CMP;
         S_UP_CMP:   state_in = flags.up_less ? S_UP_CHECK : S_HEAD;
         S_DQ_ROOT:  state_in = S_DQ_LAST;
         S_DQ_LAST:  state_in = flags.cnt_one ? S_HEAD : S_DN_CHECK;
         S_DN_CHECK: state_in = flags.dn_leaf ? S_HEAD : S_DN_LEFT;
         S_DN_LEFT:  state_in = flags.right_ok ? S_DN_RIGHT : S_DN_CMP;
         S_DN_RIGHT: state_in = S_DN_CMP;
         S_DN_CMP:   state_in = flags.dn_less ? S_DN_CHECK : S_HEAD;
         S_SR_RD:    state_in = S_SR_CMP;
         S_SR_CMP: begin
            if (flags.tag_hit)       state_in = flags.urgent ? S_HEAD : S_UP_CHECK;
            else if (flags.p_at_cnt) state_in = S_HEAD;
            else                     state_in = S_SR_RD;
         end
         S_HEAD:     state_in = S_HEAD_CAP;
         S_HEAD_CAP: state_in = S_FINISH;
         S_FINISH:   if (rsp_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      // no transfer is taken while reset is held
      req_ready    = (state_ff == S_IDLE) && !reset;
      cmd.step     = state_ff;
      cmd.load     = req_ready && req_valid;
      cmd.finish   = (state_ff == S_FINISH) && rsp_free;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready)  rsp_valid_in = 1'b0;
      if (cmd.finish) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/binary_min_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_core
// Min-heap priority queue of (priority, tag) entries held in one RAM.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake             Payload
//  req_     in   req_valid/req_ready   op, value_tag, priority_req
//  rsp_     out  rsp_valid/rsp_ready   status, value_out, priority_out,
//                                      count_out, head_tag, head_priority
//
// One item at a time. Clear and rejected ops pass decode, head read, head
// capture and finish; a sift up reads one parent per level, a sift down reads
// one or two children, the tag search one slot a step, via the one read port.
// The result register frees the core while a result waits on rsp_ready.
// Reset empties the heap at once; RAM contents are never cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hpq_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hpq_pkg::rsp_payload_type rsp_payload
);
   import hpq_pkg::*;

   cmd_type   cmd;
   flags_type flags;

   hpq_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .flags    (flags),
      .cmd      (cmd)
   );

   hpq_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_payload(req_payload),
      .flags      (flags),
      .rsp_payload(rsp_payload)
   );

endmodule

FILE: bench/binary_min_heap_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_core_tb
// Drives random and directed enqueue, dequeue, change-priority and clear
// requests into the heap core, predicts every response with a behavioral
// heap and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module binary_min_heap_priority_queue_core_tb;
   import hpq_pkg::*;

   class heap_scoreboard;
      logic [KEY_W-1:0] keys [HEAP_DEPTH];
      int               live;
      rsp_payload_type  pending [$];
      int               errors;

      function new();
         live   = 0;
         errors = 0;
      endfunction

      function logic [KEY_W-1:0] rd(int p);
         return keys[p-1];
      endfunction

      function void wr(int p, logic [KEY_W-1:0] v);
         keys[p-1] = v;
      endfunction

      function void lift(int p);
         logic [KEY_W-1:0] e;
         e = rd(p);
         while (p > 1 && e < rd(p / 2)) begin
            wr(p, rd(p / 2));
            p = p / 2;
         end
         wr(p, e);
      endfunction

      function void sink(int p);
         logic [KEY_W-1:0] e;
         logic [KEY_W-1:0] cv;
         int c;
         e = rd(p);
         forever begin
            c = p * 2;
            if (c > live) break;
            cv = rd(c);
            if (c + 1 <= live && rd(c + 1) < cv) begin
               c  = c + 1;
               cv = rd(c);
            end
            if (!(cv < e)) break;
            wr(p, cv);
            p = c;
         end
         wr(p, e);
      endfunction

      // note an accepted request and queue the response it should give
      function void note_request(req_payload_type r);
         rsp_payload_type  x;
         logic [KEY_W-1:0] k;
         int found;
         x = '0;
         x.status = ST_OK;
         case (r.op)
            OP_ENQ: begin
               if (live >= HEAP_DEPTH) x.status = ST_FULL;
               else begin
                  live++;
                  wr(live, {r.priority_req, r.value_tag});
                  lift(live);
               end
            end
            OP_DEQ: begin
               if (live == 0) x.status = ST_EMPTY;
               else begin
                  k = rd(1);
                  x.value_out    = k[TAG_W-1:0];
                  x.priority_out = k[KEY_W-1:TAG_W];
                  wr(1, rd(live));
                  live--;
                  if (live > 0) sink(1);
               end
            end
            OP_CHG: begin
               found = 0;
               for (int p = 1; p <= live; p++) begin
                  k = rd(p);
                  if (k[TAG_W-1:0] == r.value_tag) begin
                     found = p;
                     break;
                  end
               end
               if (found == 0) x.status = ST_NOT_FOUND;
               else begin
                  k = rd(found);
                  if (k[KEY_W-1:TAG_W] <= r.priority_req)
                     x.status = ST_MORE_URGENT;
                  else begin
                     wr(found, {r.priority_req, r.value_tag});
                     lift(found);
                  end
               end
            end
            default: live = 0;
         endcase
         x.count_out = live[COUNT_W-1:0];
         if (live > 0) begin
            k = rd(1);
            x.head_tag      = k[TAG_W-1:0];
            x.head_priority = k[KEY_W-1:TAG_W];
         end
         pending.push_back(x);
      endfunction

      function void check_response(rsp_payload_type a);
         rsp_payload_type e;
         if (pending.size() == 0) begin
            $error("response with nothing expected: %p", a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
         if (a.value_out !== e.value_out) begin
            $error("value_out exp %0h got %0h", e.value_out, a.value_out); errors++;
         end
         if (a.priority_out !== e.priority_out) begin
            $error("priority_out exp %0h got %0h", e.priority_out, a.priority_out);
            errors++;
         end
         if (a.count_out !== e.count_out) begin
            $error("count_out exp %0d got %0d", e.count_out, a.count_out); errors++;
         end
         if (a.head_tag !== e.head_tag) begin
            $error("head_tag exp %0h got %0h", e.head_tag, a.head_tag); errors++;
         end
         if (a.head_priority !== e.head_priority) begin
            $error("head_priority exp %0h got %0h", e.head_priority, a.head_priority);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   heap_scoreboard sb;
   bit             stall_long;
   logic [TAG_W-1:0] used_tags [$];

   binary_min_heap_priority_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(op_type op, logic [TAG_W-1:0] tag, logic [PRI_W-1:0] pri);
      req_payload_type r;
      r.op = op; r.value_tag = tag; r.priority_req = pri;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      if (op == OP_ENQ) used_tags.push_back(tag);
   endtask

   task automatic send_gap(op_type op, logic [TAG_W-1:0] tag, logic [PRI_W-1:0] pri);
      int g;
      send(op, tag, pri);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [TAG_W-1:0] pick_tag();
      if (used_tags.size() > 0 && $urandom_range(0, 3) != 0)
         return used_tags[$urandom_range(0, used_tags.size() - 1)];
      return TAG_W'($urandom());
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (stall_long) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            stall_long = 0;
         end
         g = gap_len();
         if (g > 0 && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_payload);

   initial begin
      int r, n;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      stall_long  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, extremes, ties, duplicates, full heap
      send(OP_DEQ, 16'h0, 16'h0);
      send(OP_CHG, 16'h1234, 16'h0);
      send(OP_ENQ, 16'hFFFF, 16'hFFFF);
      send(OP_ENQ, 16'h0000, 16'h0000);
      send(OP_ENQ, 16'h0005, 16'h0007);
      send(OP_ENQ, 16'h0003, 16'h0007);   // tie on priority
      send(OP_ENQ, 16'h0005, 16'h0009);   // duplicate tag
      send(OP_CHG, 16'h0005, 16'h0007);   // not lower
      send(OP_CHG, 16'h0005, 16'h0006);
      send(OP_CHG, 16'hFFFF, 16'h0000);
      send(OP_CHG, 16'hAAAA, 16'h0001);   // missing
      send(OP_DEQ, 16'h0, 16'h0);
      send(OP_DEQ, 16'h0, 16'h0);
      send(OP_CLR, 16'h0, 16'h0);
      send(OP_DEQ, 16'h0, 16'h0);
      for (int i = 0; i < HEAP_DEPTH; i++)
         send(OP_ENQ, TAG_W'($urandom()), PRI_W'($urandom_range(0, 15)));
      send(OP_ENQ, 16'h5555, 16'h0);      // full
      send(OP_CHG, 16'hFFFF, 16'h0);
      for (int i = 0; i < 3; i++) send(OP_DEQ, 16'h0, 16'h0);
      send(OP_CLR, 16'h0, 16'h0);
      drain();

      // fill while the receiver holds off
      stall_long = 1;
      for (int i = 0; i < 20; i++)
         send(OP_ENQ, TAG_W'($urandom()), PRI_W'($urandom()));
      drain();
      used_tags.delete();
      send(OP_CLR, 16'h0, 16'h0);

      n = 0;
      while (n < 300) begin
         r = $urandom_range(0, 99);
         if (r < 45)
            send_gap(OP_ENQ, TAG_W'($urandom()),
                     PRI_W'(($urandom_range(0, 1)) ? $urandom_range(0, 31) : $urandom()));
         else if (r < 75) send_gap(OP_DEQ, TAG_W'($urandom()), PRI_W'($urandom()));
         else if (r < 97) send_gap(OP_CHG, pick_tag(), PRI_W'($urandom()));
         else begin
            send_gap(OP_CLR, TAG_W'($urandom()), PRI_W'($urandom()));
            used_tags.delete();
         end
         if (used_tags.size() > 200) void'(used_tags.pop_front());
         n++;
         if (n == 150) drain();
      end
      drain();
      repeat (50) @(posedge clock);
      if (sb.errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
